[rtl/lpp_pkg.sv]
// Lift position controller package: widths, codes, reset values and the
// request, result, register and mode-status struct types.
// No dependencies; imported by every module of the block.
package lpp_pkg;

   // Field widths
   localparam int POS_FRAC_BITS = 4;
   localparam int TARGET_W      = 12;
   localparam int POS_W         = 20;
   localparam int TIME_W        = 32;
   localparam int GAIN_W        = 16;
   localparam int DRIVE_W       = 8;
   localparam int MODE_W        = 2;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   // PD datapath widths
   localparam int TGT_SCALED_W = TARGET_W + POS_FRAC_BITS + 1;
   localparam int ERR_W  = ((TGT_SCALED_W > POS_W) ? TGT_SCALED_W : POS_W) + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int NUM_W  = DIFF_W - 1 + 10;   // |diff| * 1000
   localparam int RATE_W = NUM_W - 3;         // divided by at least 10
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = RATE_W;
   localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
   localparam int ACC_W   = MUL_A_W + ERR_W + 2;
   localparam int ACC_SHIFT = 16 + POS_FRAC_BITS;
   localparam int CMP_W     = ERR_W + 8;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   // Arithmetic constants
   localparam int GAIN_SHIFT = 8;
   localparam int MIN_DT_MS  = 10;
   localparam int RATE_SCALE = 1000;
   localparam logic signed [DRIVE_W-1:0] MANUAL_DRIVE = 8'sd127;

   // Lift mode codes
   localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SCORE = 2'd2;

   // Request function codes
   localparam logic FUNC_TICK       = 1'b0;
   localparam logic FUNC_SET_TARGET = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_UP       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DOWN     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_SCALE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_POSITION = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_BAND   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT   = 3'd7;

   // Register reset values
   localparam logic [15:0] RST_GAIN_UP       = 16'd205;
   localparam logic [15:0] RST_GAIN_DOWN     = 16'd205;
   localparam logic [15:0] RST_GAIN_DERIV    = 16'd0;
   localparam logic [15:0] RST_DOWN_SCALE    = 16'd256;
   localparam logic [11:0] RST_LOAD_POSITION = 12'd160;
   localparam logic [15:0] RST_HOLD_MS       = 16'd500;
   localparam logic [7:0]  RST_SETTLE_BAND   = 8'd5;
   localparam logic [6:0]  RST_DRIVE_LIMIT   = 7'd80;

   typedef struct packed {
      logic                       func;
      logic [TIME_W-1:0]          now_ms;
      logic signed [POS_W-1:0]    position;
      logic                       l2_new_press;
      logic                       l2_held;
      logic                       r2_held;
      logic [TARGET_W-1:0]        new_target;
   } req_type;

   typedef struct packed {
      logic                       drive_brake;
      logic signed [DRIVE_W-1:0]  drive_value;
      logic [MODE_W-1:0]          lift_mode;
      logic                       auto_mode;
      logic [TARGET_W-1:0]        target_position;
   } rsp_type;

   typedef struct packed {
      logic [15:0] gain_up;
      logic [15:0] gain_down;
      logic [15:0] gain_deriv;
      logic [15:0] down_scale;
      logic [11:0] load_position;
      logic [15:0] hold_ms;
      logic [7:0]  settle_band;
      logic [6:0]  drive_limit;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [TARGET_W-1:0]        target;
      logic                       auto_mode;
      logic                       manual_run;
      logic                       brake;
      logic signed [DRIVE_W-1:0]  manual_drive;
   } mode_status_type;

endpackage

[rtl/lift_position_pd_with_modes.sv]
// Lift arm position controller, top level: request and result channels,
// register port, sequencing. Depends on lpp_pkg, lpp_mode, lpp_pd, lpp_div.
//
// Use:
//  - req_valid/req_stall/req_data carry one request. func = set target
//    loads new_target, enters autonomous mode and returns no result.
//    func = tick runs the mode machine and then either manual drive or a
//    PD step, and returns exactly one result on rsp_valid/rsp_data.
//  - A request is taken when req_valid is high and req_stall is low. The
//    block works on one request at a time and holds req_stall high until
//    its result sits in the output register.
//  - A set-target request passes T_MODE only; a manual-drive tick passes
//    T_MODE, T_DISPATCH and T_LOAD; a PD tick also waits in T_PD for the
//    PD engine, whose run is dominated by the restoring divider of the rate
//    term (one quotient bit per cycle, 31 bits). A new request waits for T_IDLE.
//  - When rsp_stall is high the result holds in the output register; a
//    finished request waits for a free slot before req_stall drops.
//  - csr_valid/csr_index/csr_wdata write one register per cycle; csr_ready
//    is always high. Write only while no request is in flight.
//  - Synchronous reset returns all registers to their defaults, mode to
//    RESET, target 0, autonomous mode off, and clears the PD history.
module lift_position_pd_with_modes (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lpp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lpp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lpp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lpp_pkg::*;

   typedef enum logic [4:0] {
      T_IDLE     = 5'b00001,
      T_MODE     = 5'b00010,
      T_DISPATCH = 5'b00100,
      T_PD       = 5'b01000,
      T_LOAD     = 5'b10000
   } top_state_type;

   top_state_type   state_ff, state_in;
   req_type         req_ff;
   cfg_type         cfg_ff, cfg_in;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   mode_status_type status;
   logic            req_take;
   logic            tick_en;
   logic            set_en;
   logic            pd_start;
   logic            pd_done;
   logic signed [DRIVE_W-1:0] pd_drive;
   logic            slot_free;

   assign req_stall = (state_ff != T_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_UP:       cfg_in.gain_up       = csr_wdata;
            CSR_GAIN_DOWN:     cfg_in.gain_down     = csr_wdata;
            CSR_GAIN_DERIV:    cfg_in.gain_deriv    = csr_wdata;
            CSR_DOWN_SCALE:    cfg_in.down_scale    = csr_wdata;
            CSR_LOAD_POSITION: cfg_in.load_position = csr_wdata[11:0];
            CSR_HOLD_MS:       cfg_in.hold_ms       = csr_wdata;
            CSR_SETTLE_BAND:   cfg_in.settle_band   = csr_wdata[7:0];
            CSR_DRIVE_LIMIT:   cfg_in.drive_limit   = csr_wdata[6:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // mode machine is applied in T_MODE, from the latched request
   assign tick_en = (state_ff == T_MODE) && (req_ff.func == FUNC_TICK);
   assign set_en  = (state_ff == T_MODE) && (req_ff.func == FUNC_SET_TARGET);

   lpp_mode u_mode (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .set_en  (set_en),
      .req     (req_ff),
      .cfg     (cfg_ff),
      .status  (status)
   );

   // PD runs on the target left by the mode machine
   assign pd_start = (state_ff == T_DISPATCH) && !status.manual_run;

   lpp_pd u_pd (
      .clock    (clock),
      .reset    (reset),
      .start    (pd_start),
      .now_ms   (req_ff.now_ms),
      .position (req_ff.position),
      .target   (status.target),
      .cfg      (cfg_ff),
      .done     (pd_done),
      .drive    (pd_drive)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         T_IDLE: if (req_take) state_in = T_MODE;
         T_MODE: begin
            if (req_ff.func == FUNC_SET_TARGET) begin
               state_in = T_IDLE;
            end else begin
               state_in = T_DISPATCH;
            end
         end
         T_DISPATCH: state_in = status.manual_run ? T_LOAD : T_PD;
         T_PD:       if (pd_done) state_in = T_LOAD;
         T_LOAD:     if (slot_free) state_in = T_IDLE;
         default:    state_in = T_IDLE;
      endcase
   end

   // result assembly; brake is only ever set on a manual tick
   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == T_LOAD && slot_free) begin
         rsp_valid_in           = 1'b1;
         rsp_in.drive_brake     = status.brake;
         rsp_in.drive_value     = status.manual_run ? status.manual_drive : pd_drive;
         rsp_in.lift_mode       = status.mode;
         rsp_in.auto_mode       = status.auto_mode;
         rsp_in.target_position = status.target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff.gain_up       <= RST_GAIN_UP;
         cfg_ff.gain_down     <= RST_GAIN_DOWN;
         cfg_ff.gain_deriv    <= RST_GAIN_DERIV;
         cfg_ff.down_scale    <= RST_DOWN_SCALE;
         cfg_ff.load_position <= RST_LOAD_POSITION;
         cfg_ff.hold_ms       <= RST_HOLD_MS;
         cfg_ff.settle_band   <= RST_SETTLE_BAND;
         cfg_ff.drive_limit   <= RST_DRIVE_LIMIT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == T_LOAD))
      else $error("result appeared outside the load step");

   a_brake_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_brake) |-> (rsp_data.drive_value == '0))
      else $error("brake result with nonzero drive");

   a_pd_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_LOAD && !status.manual_run) |->
         (pd_drive <= $signed({1'b0, cfg_ff.drive_limit}) &&
          pd_drive >= -$signed({1'b0, cfg_ff.drive_limit})))
      else $error("PD drive outside the drive limit");

   a_pd_done_owned: assert property (@(posedge clock) disable iff (reset)
      pd_done |-> (state_ff == T_PD))
      else $error("PD step finished while not awaited");
`endif

endmodule

[rtl/lpp_div.sv]
// Restoring divider, one quotient bit per cycle, for the error-rate term.
// Depends on lpp_pkg.
module lpp_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [lpp_pkg::NUM_W-1:0]  num,
   input  logic [lpp_pkg::TIME_W-1:0] den,
   output logic                      busy,
   output logic [lpp_pkg::NUM_W-1:0]  quot
);
   import lpp_pkg::*;

   logic [TIME_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [TIME_W:0]      rem_shift;
   logic [TIME_W:0]      trial;
   logic                 fits;

   // remainder stays below den, so the shifted value fits TIME_W+1 bits
   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign trial     = rem_shift - {1'b0, den};
   assign fits      = !trial[TIME_W];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         cnt_in  = DIV_CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[TIME_W-1:0] : rem_shift[TIME_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

[rtl/lpp_mode.sv]
// RESET/LOAD/SCORE mode machine, target, autonomous flag and R2 hold timer.
// Depends on lpp_pkg.
module lpp_mode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tick_en,
   input  logic                     set_en,
   input  lpp_pkg::req_type         req,
   input  lpp_pkg::cfg_type         cfg,
   output lpp_pkg::mode_status_type status
);
   import lpp_pkg::*;

   logic [MODE_W-1:0]         mode_ff, mode_in;
   logic [TARGET_W-1:0]       target_ff, target_in;
   logic                      manual_ff, manual_in;
   logic                      auto_ff, auto_in;
   logic                      hold_active_ff, hold_active_in;
   logic [TIME_W-1:0]         hold_start_ff, hold_start_in;
   logic                      run_manual_ff, run_manual_in;
   logic                      brake_ff, brake_in;
   logic signed [DRIVE_W-1:0] mdrive_ff, mdrive_in;
   logic [TIME_W-1:0]         hold_elapsed;
   logic                      hold_long;

   always_comb begin
      mode_in        = mode_ff;
      target_in      = target_ff;
      manual_in      = manual_ff;
      auto_in        = auto_ff;
      hold_active_in = hold_active_ff;
      hold_start_in  = hold_start_ff;
      run_manual_in  = run_manual_ff;
      brake_in       = brake_ff;
      mdrive_in      = mdrive_ff;
      hold_elapsed   = '0;
      hold_long      = 1'b0;
      if (set_en) begin
         target_in = req.new_target;
         auto_in   = 1'b1;
         manual_in = 1'b0;
      end else if (tick_en) begin
         run_manual_in = 1'b0;
         brake_in      = 1'b0;
         mdrive_in     = '0;
         if (!auto_ff) begin
            if (req.l2_new_press) begin
               if (mode_ff == MODE_RESET) begin
                  mode_in   = MODE_LOAD;
                  target_in = cfg.load_position;
                  manual_in = 1'b0;
               end else if (mode_ff == MODE_LOAD) begin
                  mode_in   = MODE_SCORE;
                  manual_in = 1'b1;
               end
            end
            if (mode_in == MODE_LOAD && req.r2_held) begin
               mode_in   = MODE_RESET;
               target_in = '0;
               manual_in = 1'b0;
            end
            // hold timer runs in SCORE and RESET while R2 is down
            if ((mode_in == MODE_SCORE || mode_in == MODE_RESET) && req.r2_held) begin
               if (!hold_active_in) begin
                  hold_start_in  = req.now_ms;
                  hold_active_in = 1'b1;
               end
               hold_elapsed = req.now_ms - hold_start_in;
               hold_long    = hold_elapsed > TIME_W'(cfg.hold_ms);
            end
            if (mode_in == MODE_SCORE) begin
               if (req.r2_held) begin
                  if (hold_long) begin
                     mode_in        = MODE_RESET;
                     target_in      = '0;
                     manual_in      = 1'b0;
                     hold_active_in = 1'b0;
                  end
               end else if (hold_active_in) begin
                  // short press released: back to LOAD
                  mode_in        = MODE_LOAD;
                  target_in      = cfg.load_position;
                  manual_in      = 1'b0;
                  hold_active_in = 1'b0;
               end
            end else if (mode_in == MODE_RESET && req.r2_held) begin
               if (hold_long) begin
                  target_in      = '0;
                  hold_active_in = 1'b0;
               end
            end else begin
               hold_active_in = 1'b0;
            end
            if (mode_in == MODE_SCORE && manual_in) begin
               run_manual_in = 1'b1;
               if (req.l2_held) begin
                  mdrive_in = MANUAL_DRIVE;
               end else if (req.r2_held) begin
                  mdrive_in = -MANUAL_DRIVE;
               end else begin
                  brake_in = 1'b1;
               end
            end
         end
         if (req.l2_held || req.r2_held) begin
            auto_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_RESET;
         target_ff      <= '0;
         manual_ff      <= 1'b0;
         auto_ff        <= 1'b0;
         hold_active_ff <= 1'b0;
         hold_start_ff  <= '0;
         run_manual_ff  <= 1'b0;
         brake_ff       <= 1'b0;
         mdrive_ff      <= '0;
      end else begin
         mode_ff        <= mode_in;
         target_ff      <= target_in;
         manual_ff      <= manual_in;
         auto_ff        <= auto_in;
         hold_active_ff <= hold_active_in;
         hold_start_ff  <= hold_start_in;
         run_manual_ff  <= run_manual_in;
         brake_ff       <= brake_in;
         mdrive_ff      <= mdrive_in;
      end
   end

   assign status.mode         = mode_ff;
   assign status.target       = target_ff;
   assign status.auto_mode    = auto_ff;
   assign status.manual_run   = run_manual_ff;
   assign status.brake        = brake_ff;
   assign status.manual_drive = mdrive_ff;

endmodule

[rtl/lpp_pd.sv]
// PD step engine: one shared registered multiplier and the iterative divider
// under a small sequencer; holds the previous error and time.
// Depends on lpp_pkg and lpp_div.
module lpp_pd (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [lpp_pkg::TIME_W-1:0]        now_ms,
   input  logic signed [lpp_pkg::POS_W-1:0]  position,
   input  logic [lpp_pkg::TARGET_W-1:0]      target,
   input  lpp_pkg::cfg_type                  cfg,
   output logic                              done,
   output logic signed [lpp_pkg::DRIVE_W-1:0] drive
);
   import lpp_pkg::*;

   typedef enum logic [9:0] {
      P_IDLE = 10'b00_0000_0001,
      P_ERR  = 10'b00_0000_0010,
      P_RMUL = 10'b00_0000_0100,
      P_GMUL = 10'b00_0000_1000,
      P_EMUL = 10'b00_0001_0000,
      P_ACC  = 10'b00_0010_0000,
      P_DIV  = 10'b00_0100_0000,
      P_DMUL = 10'b00_1000_0000,
      P_SUM  = 10'b01_0000_0000,
      P_FIN  = 10'b10_0000_0000
   } pd_state_type;

   pd_state_type state_ff, state_in;

   logic signed [ERR_W-1:0]   prev_error_ff, prev_error_in;
   logic [TIME_W-1:0]         prev_time_ff, prev_time_in;
   logic signed [ERR_W-1:0]   e_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic [TIME_W-1:0]         dt_ff;
   logic signed [RATE_W-1:0]  rate_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic                      done_ff;

   logic signed [ERR_W-1:0]   e_calc;
   logic signed [DIFF_W-1:0]  diff_calc;
   logic [TIME_W-1:0]         elapsed;
   logic [DIFF_W-2:0]         diff_mag;
   logic                      e_pos;
   logic [MUL_A_W-1:0]        mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic                      div_start;
   logic                      div_busy;
   logic [NUM_W-1:0]          div_quot;
   logic signed [RATE_W-1:0]  q_trunc;
   logic signed [ACC_W-1:0]   lim;
   logic signed [ACC_W-1:0]   acc_clamp;
   logic [ACC_W-1:0]          acc_mag;
   logic [ACC_W-1:0]          acc_shr;
   logic [DRIVE_W-2:0]        drive_mag;
   logic signed [DRIVE_W-1:0] drive_calc;
   logic [ERR_W-1:0]          e_mag;
   logic                      settled;

   assign e_calc    = $signed(ERR_W'(target) << POS_FRAC_BITS) - ERR_W'(position);
   assign diff_calc = DIFF_W'(e_calc) - DIFF_W'(prev_error_ff);
   assign elapsed   = now_ms - prev_time_ff;
   assign diff_mag  = diff_ff[DIFF_W-1] ? (DIFF_W-1)'(-diff_ff) : (DIFF_W-1)'(diff_ff);
   assign e_pos     = !e_ff[ERR_W-1] && (e_ff != '0);

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         P_RMUL: begin
            mul_a = MUL_A_W'(RATE_SCALE);
            mul_b = $signed(MUL_B_W'(diff_mag));
         end
         P_GMUL: begin
            mul_a = MUL_A_W'(cfg.gain_down);
            mul_b = $signed(MUL_B_W'(cfg.down_scale));
         end
         P_EMUL: begin
            mul_a = e_pos ? (MUL_A_W'(cfg.gain_up) << GAIN_SHIFT) : prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(e_ff);
         end
         P_DMUL: begin
            mul_a = MUL_A_W'(cfg.gain_deriv) << GAIN_SHIFT;
            mul_b = rate_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign div_start = (state_ff == P_GMUL);

   lpp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod_ff[NUM_W-1:0]),
      .den   (dt_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   assign q_trunc = $signed(div_quot[RATE_W-1:0]);

   // clamp, scale down toward zero, settle window
   assign lim       = $signed(ACC_W'(cfg.drive_limit) << ACC_SHIFT);
   assign acc_clamp = (acc_ff > lim) ? lim : ((acc_ff < -lim) ? -lim : acc_ff);
   assign acc_mag   = acc_clamp[ACC_W-1] ? ACC_W'(-acc_clamp) : ACC_W'(acc_clamp);
   assign acc_shr   = acc_mag >> ACC_SHIFT;
   assign drive_mag = acc_shr[DRIVE_W-2:0];
   assign drive_calc = acc_clamp[ACC_W-1] ? -$signed({1'b0, drive_mag})
                                          : $signed({1'b0, drive_mag});
   assign e_mag   = e_ff[ERR_W-1] ? ERR_W'(-e_ff) : ERR_W'(e_ff);
   assign settled = (target == '0) &&
                    (CMP_W'(e_mag) < (CMP_W'(cfg.settle_band) << POS_FRAC_BITS));

   always_comb begin
      state_in      = state_ff;
      prev_error_in = prev_error_ff;
      prev_time_in  = prev_time_ff;
      case (state_ff)
         P_IDLE: if (start) state_in = P_ERR;
         P_ERR:  state_in = P_RMUL;
         P_RMUL: state_in = P_GMUL;
         P_GMUL: state_in = P_EMUL;
         P_EMUL: state_in = P_ACC;
         P_ACC:  state_in = P_DIV;
         P_DIV:  if (!div_busy) state_in = P_DMUL;
         P_DMUL: state_in = P_SUM;
         P_SUM:  state_in = P_FIN;
         P_FIN: begin
            state_in      = P_IDLE;
            prev_error_in = e_ff;
            prev_time_in  = now_ms;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= P_IDLE;
         prev_error_ff <= '0;
         prev_time_ff  <= '0;
         done_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_error_ff <= prev_error_in;
         prev_time_ff  <= prev_time_in;
         done_ff       <= (state_ff == P_FIN);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, mul_a}) * mul_b;
      if (state_ff == P_ERR) begin
         e_ff    <= e_calc;
         diff_ff <= diff_calc;
         dt_ff   <= (elapsed < TIME_W'(MIN_DT_MS)) ? TIME_W'(MIN_DT_MS) : elapsed;
      end
      if (state_ff == P_DIV && !div_busy) begin
         rate_ff <= diff_ff[DIFF_W-1] ? -q_trunc : q_trunc;
      end
      if (state_ff == P_ACC) begin
         acc_ff <= $signed(prod_ff[ACC_W-1:0]);
      end else if (state_ff == P_SUM) begin
         acc_ff <= acc_ff + $signed(prod_ff[ACC_W-1:0]);
      end
      if (state_ff == P_FIN) begin
         drive_ff <= settled ? '0 : drive_calc;
      end
   end

   assign done  = done_ff;
   assign drive = drive_ff;

endmodule

[tb/sv/lift_position_pd_with_modes_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the lift arm position controller: directed and random
// requests under several register settings and idling patterns, with an in-bench
// predictor of the mode machine and PD loop. Depends on lpp_pkg and the block only.
module lift_position_pd_with_modes_tb;
   import lpp_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int DRAIN_CYCLES = 60;     // covers a PD tick, with margin
   localparam int SHOW_ERRORS  = 10;

   typedef enum {SET_NOMINAL, SET_HIGHEST, SET_LOWEST, SET_RANDOM} setting_kind_e;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

   // DUT connections; every input starts at a known value
   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Predictor state: register copy plus the controller's own state
   cfg_type                model_cfg;
   logic [MODE_W-1:0]      lift_mode;
   logic [TARGET_W-1:0]    lift_target;
   bit                     lift_manual, lift_auto, hold_active;
   longint                 lift_prev_err;
   logic [TIME_W-1:0]      lift_prev_ms, hold_start;

   rsp_type                pending_commands[$];   // predicted motor commands, oldest first
   int                     error_count   = 0;
   int                     cycle_count   = 0;
   int                     items_sent    = 0;
   int                     send_idle_pct = 0;
   int                     rsp_stall_pct = 0;
   int                     hold_off_left = 0;
   logic [TIME_W-1:0]      sim_ms        = '0;

   lift_position_pd_with_modes u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("lift_position_pd_with_modes test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   task automatic clear_model();
      model_cfg.gain_up       = RST_GAIN_UP;
      model_cfg.gain_down     = RST_GAIN_DOWN;
      model_cfg.gain_deriv    = RST_GAIN_DERIV;
      model_cfg.down_scale    = RST_DOWN_SCALE;
      model_cfg.load_position = RST_LOAD_POSITION;
      model_cfg.hold_ms       = RST_HOLD_MS;
      model_cfg.settle_band   = RST_SETTLE_BAND;
      model_cfg.drive_limit   = RST_DRIVE_LIMIT;
      lift_mode     = MODE_RESET;
      lift_target   = '0;
      lift_manual   = 1'b0;
      lift_auto     = 1'b0;
      hold_active   = 1'b0;
      lift_prev_err = 0;
      lift_prev_ms  = '0;
      hold_start    = '0;
   endtask

   // One PD step: P term with up/down gains, D term over max(elapsed, 10 ms),
   // clamp, truncate toward zero, zero drive when settled at target 0.
   function automatic longint pd_command(input logic [TIME_W-1:0] now, input longint pos);
      longint err, dt, err_rate, acc, lim, cmd, mag;
      logic [TIME_W-1:0] elapsed;
      err     = (longint'(lift_target) <<< POS_FRAC_BITS) - pos;
      elapsed = now - lift_prev_ms;
      dt      = (elapsed < MIN_DT_MS) ? longint'(MIN_DT_MS) : longint'(elapsed);
      err_rate = ((err - lift_prev_err) * RATE_SCALE) / dt;
      if (err > 0)
         acc = longint'(model_cfg.gain_up) * err * 256;
      else
         acc = longint'(model_cfg.gain_down) * err * longint'(model_cfg.down_scale);
      acc += longint'(model_cfg.gain_deriv) * err_rate * 256;
      lim = longint'(model_cfg.drive_limit) <<< ACC_SHIFT;
      if (acc > lim)  acc = lim;
      if (acc < -lim) acc = -lim;
      cmd = acc / (longint'(1) <<< ACC_SHIFT);
      mag = (err < 0) ? -err : err;
      if (lift_target == '0 && mag < (longint'(model_cfg.settle_band) <<< POS_FRAC_BITS))
         cmd = 0;
      lift_prev_err = err;
      lift_prev_ms  = now;
      return cmd;
   endfunction

   function automatic void enter_mode(input logic [MODE_W-1:0] m,
                                      input logic [TARGET_W-1:0] tgt);
      lift_mode   = m;
      lift_target = tgt;
      lift_manual = 1'b0;
      lift_auto   = 1'b0;
   endfunction

   // Advances the predictor by one request; returns 1 when a result is due.
   function automatic bit advance_lift(input req_type r, output rsp_type cmd_out);
      longint drv;
      bit brake;
      logic [TIME_W-1:0] held_for;
      drv = 0;
      brake = 1'b0;
      cmd_out = '0;
      if (r.func == FUNC_SET_TARGET) begin
         lift_target = r.new_target;
         lift_auto   = 1'b1;
         lift_manual = 1'b0;
         return 1'b0;
      end
      if (lift_auto) begin
         drv = pd_command(r.now_ms, longint'(signed'(r.position)));
      end else begin
         if (r.l2_new_press) begin
            if (lift_mode == MODE_RESET) begin
               enter_mode(MODE_LOAD, model_cfg.load_position);
            end else if (lift_mode == MODE_LOAD) begin
               lift_mode   = MODE_SCORE;
               lift_manual = 1'b1;
               lift_auto   = 1'b0;
            end
         end
         if (lift_mode == MODE_LOAD && r.r2_held)
            enter_mode(MODE_RESET, '0);
         if (lift_mode == MODE_SCORE) begin
            if (r.r2_held) begin
               if (!hold_active) begin
                  hold_start  = r.now_ms;
                  hold_active = 1'b1;
               end
               held_for = r.now_ms - hold_start;
               if (held_for > model_cfg.hold_ms) begin
                  enter_mode(MODE_RESET, '0);
                  hold_active = 1'b0;
               end
            end else if (hold_active) begin
               // short tap in score drops back to load
               enter_mode(MODE_LOAD, model_cfg.load_position);
               hold_active = 1'b0;
            end
         end else if (lift_mode == MODE_RESET && r.r2_held) begin
            if (!hold_active) begin
               hold_start  = r.now_ms;
               hold_active = 1'b1;
            end
            held_for = r.now_ms - hold_start;
            if (held_for > model_cfg.hold_ms) begin
               lift_target = '0;
               hold_active = 1'b0;
            end
         end else begin
            hold_active = 1'b0;
         end
         if (lift_mode == MODE_SCORE && lift_manual) begin
            if (r.l2_held)      drv = 127;
            else if (r.r2_held) drv = -127;
            else                brake = 1'b1;
         end else begin
            drv = pd_command(r.now_ms, longint'(signed'(r.position)));
         end
      end
      if (r.l2_held || r.r2_held)
         lift_auto = 1'b0;
      cmd_out.drive_brake     = brake;
      cmd_out.drive_value     = drv[DRIVE_W-1:0];
      cmd_out.lift_mode       = lift_mode;
      cmd_out.auto_mode       = lift_auto;
      cmd_out.target_position = lift_target;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= SHOW_ERRORS)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_commands.size() == 0) begin
            flag_error($sformatf("unexpected result at cycle %0d: %p", cycle_count, rsp_data));
         end else begin
            want = pending_commands.pop_front();
            if (rsp_data.drive_brake     !== want.drive_brake ||
                rsp_data.drive_value     !== want.drive_value ||
                rsp_data.lift_mode       !== want.lift_mode   ||
                rsp_data.auto_mode       !== want.auto_mode   ||
                rsp_data.target_position !== want.target_position)
               flag_error($sformatf(
                  "mismatch at cycle %0d: expected brake %0b drive %0d mode %0d auto %0b tgt %0d, got brake %0b drive %0d mode %0d auto %0b tgt %0d",
                  cycle_count, want.drive_brake, want.drive_value, want.lift_mode,
                  want.auto_mode, want.target_position, rsp_data.drive_brake,
                  rsp_data.drive_value, rsp_data.lift_mode, rsp_data.auto_mode,
                  rsp_data.target_position));
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall     <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Drivers; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------
   task automatic set_idling(input idle_mode_e m);
      send_idle_pct = (m == IDLE_SENDER)   ? 63 : (m == IDLE_BOTH) ? 7 : 0;
      rsp_stall_pct = (m == IDLE_RECEIVER) ? 63 : (m == IDLE_BOTH) ? 7 : 0;
   endtask

   task automatic send_request(input req_type r);
      rsp_type cmd;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (advance_lift(r, cmd))
         pending_commands.push_back(cmd);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [TIME_W-1:0] t, input int pos,
                            input bit l2n, input bit l2, input bit r2);
      req_type r;
      r              = '0;
      r.func         = FUNC_TICK;
      r.now_ms       = t;
      r.position     = pos[POS_W-1:0];
      r.l2_new_press = l2n;
      r.l2_held      = l2;
      r.r2_held      = r2;
      r.new_target   = TARGET_W'($urandom);   // don't care on ticks
      send_request(r);
   endtask

   task automatic send_target(input logic [TARGET_W-1:0] tgt);
      req_type r;
      r            = {$urandom, $urandom, $urandom};   // other fields are don't care
      r.func       = FUNC_SET_TARGET;
      r.new_target = tgt;
      send_request(r);
   endtask

   // Drop valid, wait for all predicted results, then let the block go quiet
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_commands.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_UP:       model_cfg.gain_up       = data;
         CSR_GAIN_DOWN:     model_cfg.gain_down     = data;
         CSR_GAIN_DERIV:    model_cfg.gain_deriv    = data;
         CSR_DOWN_SCALE:    model_cfg.down_scale    = data;
         CSR_LOAD_POSITION: model_cfg.load_position = data[11:0];
         CSR_HOLD_MS:       model_cfg.hold_ms       = data;
         CSR_SETTLE_BAND:   model_cfg.settle_band   = data[7:0];
         CSR_DRIVE_LIMIT:   model_cfg.drive_limit   = data[6:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Writes all eight registers; narrow ones get junk in the unused upper bits
   task automatic load_settings(input cfg_type s);
      write_register(CSR_GAIN_UP,       s.gain_up);
      write_register(CSR_GAIN_DOWN,     s.gain_down);
      write_register(CSR_GAIN_DERIV,    s.gain_deriv);
      write_register(CSR_DOWN_SCALE,    s.down_scale);
      write_register(CSR_LOAD_POSITION, {4'($urandom), s.load_position});
      write_register(CSR_HOLD_MS,       s.hold_ms);
      write_register(CSR_SETTLE_BAND,   {8'($urandom), s.settle_band});
      write_register(CSR_DRIVE_LIMIT,   {9'($urandom), s.drive_limit});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_gain();
      return ($urandom_range(1)) ? 16'($urandom_range(1023)) : 16'($urandom);
   endfunction

   function automatic cfg_type make_settings(input setting_kind_e kind);
      cfg_type s;
      case (kind)
         SET_HIGHEST: s = '1;
         SET_LOWEST:  s = '0;
         SET_RANDOM: begin
            s.gain_up       = pick_gain();
            s.gain_down     = pick_gain();
            s.gain_deriv    = pick_gain();
            s.down_scale    = pick_gain();
            s.load_position = TARGET_W'($urandom);
            s.hold_ms       = ($urandom_range(9) < 7) ? 16'($urandom_range(300))
                                                      : 16'($urandom);
            s.settle_band   = 8'($urandom);
            s.drive_limit   = 7'($urandom);
         end
         default: begin
            s.gain_up       = RST_GAIN_UP;
            s.gain_down     = RST_GAIN_DOWN;
            s.gain_deriv    = 16'd512;
            s.down_scale    = RST_DOWN_SCALE;
            s.load_position = RST_LOAD_POSITION;
            s.hold_ms       = RST_HOLD_MS;
            s.settle_band   = RST_SETTLE_BAND;
            s.drive_limit   = RST_DRIVE_LIMIT;
         end
      endcase
      return s;
   endfunction

   // ---------------------------------------------------------------------
   // Random stimulus
   // ---------------------------------------------------------------------
   task automatic advance_ms();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70)      sim_ms += 10;
      else if (pick < 85) sim_ms += $urandom_range(9);
      else if (pick < 95) sim_ms += $urandom_range(3000);
      else                sim_ms = $urandom;   // jump, may wrap
   endtask

   // Encoder reading mostly near the current target, sometimes anywhere
   function automatic int near_position();
      longint base, band;
      int unsigned pick;
      base = longint'(lift_target) <<< POS_FRAC_BITS;
      band = (longint'(model_cfg.settle_band) <<< POS_FRAC_BITS) + 32;
      pick = $urandom_range(19);
      if (pick < 10)
         return int'(base + longint'($urandom_range(256)) - 128);
      else if (pick < 15)
         return int'(base + longint'($urandom_range(2 * band)) - band);
      else if (pick < 18)
         return int'(base + longint'($urandom_range(16384)) - 8192);
      else
         return int'($urandom);
   endfunction

   // R2 held across several ticks, total length just below, at or past hold_ms
   task automatic r2_hold_sequence();
      int unsigned k, dur, hold;
      logic [TIME_W-1:0] t0;
      hold = model_cfg.hold_ms;
      k    = $urandom_range(4, 2);
      case ($urandom_range(3))
         0: dur = hold;
         1: dur = hold + 1;
         2: dur = (hold > 0) ? hold - 1 : 0;
         default: dur = $urandom_range(2 * hold + 20);
      endcase
      advance_ms();
      t0 = sim_ms;
      for (int i = 0; i < k; i++)
         send_tick(t0 + dur * i / (k - 1), near_position(),
                   (i == 0) && ($urandom_range(3) == 0), ($urandom_range(7) == 0), 1'b1);
      sim_ms = t0 + dur;
      if ($urandom_range(9) < 7) begin
         advance_ms();
         send_tick(sim_ms, near_position(), 1'b0, 1'b0, 1'b0);
      end
   endtask

   task automatic random_traffic(input int n);
      int start, pick, k;
      req_type r;
      start = items_sent;
      while (items_sent - start < n) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_target(($urandom_range(3) == 0) ? '0 : TARGET_W'($urandom));
         end else if (pick < 30) begin
            // mode walk: a fresh L2 press followed by a few ticks
            advance_ms();
            send_tick(sim_ms, near_position(), 1'b1, $urandom_range(1), 1'b0);
            k = $urandom_range(3, 1);
            for (int i = 0; i < k; i++) begin
               advance_ms();
               send_tick(sim_ms, near_position(), 1'b0, $urandom_range(1),
                         ($urandom_range(4) == 0));
            end
         end else if (pick < 55) begin
            r2_hold_sequence();
         end else if (pick < 90) begin
            advance_ms();
            send_tick(sim_ms, near_position(), ($urandom_range(9) == 0),
                      ($urandom_range(6) == 0), ($urandom_range(6) == 0));
         end else begin
            // noise: every field random
            r = {$urandom, $urandom, $urandom};
            send_request(r);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes, each mode transition, hold boundaries, settle band,
   // autonomous entry and exit, time wrap and the minimum time step.
   task automatic test_directed();
      set_idling(IDLE_NONE);
      send_tick(32'd0, 0, 1'b0, 1'b0, 1'b0);               // zero time, settled at 0
      send_tick(32'd10, 524287, 1'b0, 1'b0, 1'b0);         // largest position
      send_tick(32'd20, -524288, 1'b0, 1'b0, 1'b0);        // smallest position
      send_tick(32'd100, 0, 1'b0, 1'b0, 1'b1);             // R2 hold starts in reset
      send_tick(32'd600, 0, 1'b0, 1'b0, 1'b1);             // exactly hold_ms: not long
      send_tick(32'd601, 0, 1'b0, 1'b0, 1'b1);             // one past: long press
      send_tick(32'd611, 0, 1'b0, 1'b0, 1'b0);             // release
      send_tick(32'd621, 2560, 1'b1, 1'b1, 1'b0);          // reset -> load
      send_tick(32'd631, 2000, 1'b0, 1'b0, 1'b1);          // R2 in load -> reset
      send_tick(32'd641, 2000, 1'b1, 1'b0, 1'b0);          // reset -> load
      send_tick(32'd651, 2000, 1'b1, 1'b1, 1'b0);          // load -> score, drive up
      send_tick(32'd661, 2000, 1'b0, 1'b0, 1'b1);          // score R2 tap starts
      send_tick(32'd671, 2000, 1'b0, 1'b0, 1'b0);          // tap released -> load
      send_tick(32'd681, 2000, 1'b1, 1'b0, 1'b0);          // load -> score, brake
      send_tick(32'd691, 2000, 1'b1, 1'b1, 1'b0);          // press in score ignored
      send_tick(32'd701, 2000, 1'b0, 1'b0, 1'b1);          // long hold in score
      send_tick(32'd1202, 2000, 1'b0, 1'b0, 1'b1);         // past hold_ms -> reset
      send_target(12'd4095);                               // autonomous, top target
      send_tick(32'd1212, 100, 1'b1, 1'b0, 1'b0);          // auto PD, press ignored
      send_tick(32'd1215, 100, 1'b0, 1'b1, 1'b0);          // short step, L2 ends auto
      send_target(12'd0);
      send_tick(32'hFFFF_FFF0, 64, 1'b0, 1'b0, 1'b0);      // inside settle band
      send_tick(32'd5, -80, 1'b0, 1'b0, 1'b0);             // band edge, time wraps
      send_tick(32'd5, 80, 1'b0, 1'b0, 1'b1);              // zero elapsed
      wait_drain();
   endtask

   // Several register settings, extremes included, each with its own idling
   task automatic test_settings_sweep();
      setting_kind_e kinds[8] = '{SET_NOMINAL, SET_HIGHEST, SET_LOWEST, SET_RANDOM,
                                  SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_NOMINAL};
      for (int i = 0; i < 8; i++) begin
         load_settings(make_settings(kinds[i]));
         set_idling(idle_mode_e'(i % 4));
         random_traffic(95);
         wait_drain();
      end
   endtask

   // Receiver holds off long enough for the block to fill and stall its input,
   // then the sender pauses until every result is back; a second round runs with both sides idling.
   task automatic test_backpressure();
      load_settings(make_settings(SET_RANDOM));
      set_idling(IDLE_NONE);
      hold_off_left = 400;
      random_traffic(24);
      wait_drain();
      set_idling(IDLE_BOTH);
      random_traffic(16);
      wait_drain();
   endtask

   initial begin
      clear_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_settings_sweep();
      test_backpressure();

      if (pending_commands.size() != 0)
         flag_error($sformatf("%0d results never arrived", pending_commands.size()));
      if (error_count == 0)
         $display("lift_position_pd_with_modes test passed");
      else
         $display("lift_position_pd_with_modes test failed");
      $finish;
   end

endmodule
